@@ design/zdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// zdsm_pkg
// types and constants shared by the zone dwell state machine modules
// ----------------------------------------------------------------------------
package zdsm_pkg;

    // dwell phases
    localparam logic [1:0] PH_ABSENT   = 2'd0;
    localparam logic [1:0] PH_PEND_IN  = 2'd1;
    localparam logic [1:0] PH_IN       = 2'd2;
    localparam logic [1:0] PH_PEND_OUT = 2'd3;

    // event kinds
    localparam logic [1:0] EV_ENTERED   = 2'd0;
    localparam logic [1:0] EV_THRESHOLD = 2'd1;
    localparam logic [1:0] EV_UPDATE    = 2'd2;
    localparam logic [1:0] EV_EXITED    = 2'd3;

    // step unit operations
    localparam logic [1:0] OP_PASS  = 2'd0;
    localparam logic [1:0] OP_UPD   = 2'd1;
    localparam logic [1:0] OP_FEXIT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_ZONES  = 3'd0;
    localparam logic [2:0] CFG_ENTER  = 3'd1;
    localparam logic [2:0] CFG_EXIT   = 3'd2;
    localparam logic [2:0] CFG_THRESH = 3'd3;
    localparam logic [2:0] CFG_PERIOD = 3'd4;

    // register reset values
    localparam logic [3:0]  RST_ZONES  = 4'd8;
    localparam logic [21:0] RST_ENTER  = 22'd1000;
    localparam logic [21:0] RST_EXIT   = 22'd1000;
    localparam logic [26:0] RST_THRESH = 27'd60000;
    localparam logic [26:0] RST_PERIOD = 27'd0;

    // stream widths
    localparam int IN_W  = 48;
    localparam int OUT_W = 112;

    typedef struct packed {
        logic [1:0]  phase;
        logic        memb;
        logic [31:0] first;
        logic [31:0] origin;
        logic [31:0] lastin;
        logic [31:0] left;
        logic [31:0] report;
        logic        thr;
    } t_entry;

    typedef struct packed {
        logic [3:0]  zones;
        logic [21:0] enter;
        logic [21:0] leave;
        logic [26:0] thresh;
        logic [26:0] period;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        logic [1:0]  kind;
        logic [31:0] elapsed;
        logic        thr;
    } t_event;

    typedef struct packed {
        logic done;
        logic upd;
    } t_step_res;

endpackage

@@ design/zone_dwell_state_machine.sv @@
// ----------------------------------------------------------------------------
// zone_dwell_state_machine
// debounced dwell tracking per track slot and zone, raising dwell events
// ----------------------------------------------------------------------------
// an item goes through accept, load, one to three phase passes, an optional
// update pass and write-back; one phase pass per cycle unless an event must wait
// for output room; the first event of an item reaches the output register from
// the held event register; an item for an inactive zone or slot is taken with
// no event; after reset the state memory is cleared entry by entry, during
// which no item is taken; configuration writes are always taken
module zone_dwell_state_machine #(
    parameter int TRACK_SLOTS = 64,
    parameter int ZONE_SLOTS  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    // item stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // slot[5:0] zone[8:6] now_ms[40:9] seen[41] inside_req[42] eligible[43]
    // fexit[44], zero fill to 48 bits
    input  logic [zdsm_pkg::IN_W-1:0]  s_tdata,
    // event stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_slot[5:0] out_zone[8:6] elapsed_ms[40:9] thr_hit[41]
    // overage_ms[73:42] event_time_ms[105:74], zero fill to 112 bits
    output logic [zdsm_pkg::OUT_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast
);

    localparam int DEPTH = TRACK_SLOTS * ZONE_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [AW-1:0]    r_clr_idx;
    zdsm_pkg::t_cfg   r_cfg;

    // state memory, one entry per slot and zone
    zdsm_pkg::t_entry r_mem [DEPTH];
    zdsm_pkg::t_entry r_rdata;
    zdsm_pkg::t_entry r_work;
    zdsm_pkg::t_entry n_work;

    // current item
    logic [5:0]       r_slot;
    logic [2:0]       r_zone;
    logic [31:0]      r_now;
    logic             r_seen;
    logic             r_ins;
    logic             r_elig;
    logic             r_fexit;
    logic [AW-1:0]    r_idx;

    // held event, sent once the next one shows whether it is the last
    logic             r_pvalid;
    logic [1:0]       r_pkind;
    logic [31:0]      r_pel;
    logic             r_pthr;

    // output register
    logic             r_ovalid;
    logic [5:0]       r_o_slot;
    logic [2:0]       r_o_zone;
    logic [1:0]       r_o_kind;
    logic [31:0]      r_o_el;
    logic             r_o_thr;
    logic [31:0]      r_o_over;
    logic [31:0]      r_o_time;
    logic             r_o_last;

    logic [5:0]       in_slot;
    logic [2:0]       in_zone;
    logic             in_acc;
    logic             in_active;
    logic [AW-1:0]    in_idx;

    logic [1:0]       step_op;
    zdsm_pkg::t_entry step_nxt;
    zdsm_pkg::t_event step_evt;
    zdsm_pkg::t_step_res step_res;

    logic             out_free;
    logic             stepping;
    logic             adv;
    logic             push;
    logic             push_last;
    logic             flush_ok;
    logic [31:0]      p_over;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    zdsm_pkg::t_entry mem_wdata;

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    assign in_slot   = s_tdata[5:0];
    assign in_zone   = s_tdata[8:6];
    assign s_tready  = (r_state == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    // slots beyond the store or zones beyond the active set are dropped
    assign in_active = (32'(in_slot) < TRACK_SLOTS) && (32'(in_zone) < ZONE_SLOTS) &&
                       ({1'b0, in_zone} < r_cfg.zones);
    assign in_idx    = AW'(32'(in_slot) * ZONE_SLOTS + 32'(in_zone));

    // ------------------------------------------------------------------
    // configuration registers, written whenever offered
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zones  <= zdsm_pkg::RST_ZONES;
            r_cfg.enter  <= zdsm_pkg::RST_ENTER;
            r_cfg.leave  <= zdsm_pkg::RST_EXIT;
            r_cfg.thresh <= zdsm_pkg::RST_THRESH;
            r_cfg.period <= zdsm_pkg::RST_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                zdsm_pkg::CFG_ZONES:  r_cfg.zones  <= i_cfg_data[3:0];
                zdsm_pkg::CFG_ENTER:  r_cfg.enter  <= i_cfg_data[21:0];
                zdsm_pkg::CFG_EXIT:   r_cfg.leave  <= i_cfg_data[21:0];
                zdsm_pkg::CFG_THRESH: r_cfg.thresh <= i_cfg_data[26:0];
                zdsm_pkg::CFG_PERIOD: r_cfg.period <= i_cfg_data[26:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state memory: clearing pass after reset, write-back at item end
    // ------------------------------------------------------------------
    assign mem_we    = (r_state == ST_CLEAR) || (r_state == ST_DONE);
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_idx;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : r_work;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rdata <= r_mem[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // phase machine pass
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            ST_UPD:  step_op = zdsm_pkg::OP_UPD;
            default: step_op = r_fexit ? zdsm_pkg::OP_FEXIT : zdsm_pkg::OP_PASS;
        endcase
    end

    zdsm_step u_step (
        .i_op   (step_op),
        .i_cur  (r_work),
        .i_now  (r_now),
        .i_elig (r_elig),
        .i_cfg  (r_cfg),
        .o_nxt  (step_nxt),
        .o_evt  (step_evt),
        .o_res  (step_res)
    );

    assign out_free = !r_ovalid || m_tready;
    assign stepping = (r_state == ST_STEP) || (r_state == ST_UPD);
    // a new event displaces the held one, which needs room at the output
    assign adv      = !(step_evt.vld && r_pvalid && !out_free);
    assign flush_ok = !r_pvalid || out_free;

    assign push      = (stepping && adv && step_evt.vld && r_pvalid) ||
                       (r_state == ST_DONE && r_pvalid && out_free);
    assign push_last = (r_state == ST_DONE);

    // overage is worked out on the way to the output register
    assign p_over = (r_pkind == zdsm_pkg::EV_ENTERED) ? 32'd0 :
                    (r_pel > 32'(r_cfg.thresh)) ? (r_pel - 32'(r_cfg.thresh)) : 32'd0;

    // sighting is folded into the entry as it is loaded
    always_comb begin
        n_work = r_rdata;
        if (r_seen) begin
            if (r_ins && !r_rdata.memb) begin
                n_work.first = r_now;
            end
            if (r_ins) begin
                n_work.lastin = r_now;
            end
            n_work.memb = r_ins;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && in_active) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_STEP;
            ST_STEP: begin
                if (adv) begin
                    if (step_res.upd) begin
                        n_state = ST_UPD;
                    end else if (step_res.done) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_UPD: begin
                if (adv) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (flush_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_pvalid  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            // held event
            if (stepping && adv && step_evt.vld) begin
                r_pvalid <= 1'b1;
            end else if (r_state == ST_DONE && out_free) begin
                r_pvalid <= 1'b0;
            end
            // output register
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot  <= in_slot;
            r_zone  <= in_zone;
            r_now   <= s_tdata[40:9];
            r_seen  <= s_tdata[41];
            r_ins   <= s_tdata[42];
            r_elig  <= s_tdata[43];
            r_fexit <= s_tdata[44];
            r_idx   <= in_idx;
        end
        if (r_state == ST_LOAD) begin
            r_work <= n_work;
        end else if (stepping && adv) begin
            r_work <= step_nxt;
        end
        if (stepping && adv && step_evt.vld) begin
            r_pkind <= step_evt.kind;
            r_pel   <= step_evt.elapsed;
            r_pthr  <= step_evt.thr;
        end
        if (push) begin
            r_o_slot <= r_slot;
            r_o_zone <= r_zone;
            r_o_kind <= r_pkind;
            r_o_el   <= r_pel;
            r_o_thr  <= r_pthr;
            r_o_over <= p_over;
            r_o_time <= r_now;
            r_o_last <= push_last;
        end
    end

    // ------------------------------------------------------------------
    // event stream
    // ------------------------------------------------------------------
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {6'd0, r_o_time, r_o_over, r_o_thr, r_o_el, r_o_zone, r_o_slot};
    assign m_tuser  = r_o_kind;
    assign m_tlast  = r_o_last;

endmodule

@@ design/zdsm_step.sv @@
// ----------------------------------------------------------------------------
// zdsm_step
// one pass of the dwell phase machine over the entry held in the work register
// ----------------------------------------------------------------------------
module zdsm_step (
    input  logic [1:0]       i_op,
    input  zdsm_pkg::t_entry i_cur,
    input  logic [31:0]      i_now,
    input  logic             i_elig,
    input  zdsm_pkg::t_cfg   i_cfg,
    output zdsm_pkg::t_entry o_nxt,
    output zdsm_pkg::t_event o_evt,
    output zdsm_pkg::t_step_res o_res
);

    logic [31:0] d_first;
    logic [31:0] d_origin;
    logic [31:0] d_report;
    logic [31:0] d_left;
    logic [31:0] d_inside;
    logic [31:0] e_now;

    // wrapped differences, sign bit set means negative
    assign d_first  = i_now - i_cur.first;
    assign d_origin = i_now - i_cur.origin;
    assign d_report = i_now - i_cur.report;
    assign d_left   = i_now - i_cur.left;
    assign d_inside = i_cur.lastin - i_cur.origin;
    assign e_now    = d_origin[31] ? 32'd0 : d_origin;

    always_comb begin
        o_nxt = i_cur;
        o_evt = '0;
        o_res = '0;
        case (i_op)
            zdsm_pkg::OP_FEXIT: begin
                if (i_cur.phase == zdsm_pkg::PH_IN || i_cur.phase == zdsm_pkg::PH_PEND_OUT) begin
                    o_evt.vld     = 1'b1;
                    o_evt.kind    = zdsm_pkg::EV_EXITED;
                    o_evt.elapsed = (!d_inside[31] && d_inside != 32'd0) ? d_inside : e_now;
                    o_evt.thr     = i_cur.thr;
                end
                o_nxt     = '0;
                o_res.done = 1'b1;
            end
            zdsm_pkg::OP_UPD: begin
                if (i_cfg.period != 27'd0 && !d_report[31] && d_report >= 32'(i_cfg.period)) begin
                    o_nxt.report  = i_now;
                    o_evt.vld     = 1'b1;
                    o_evt.kind    = zdsm_pkg::EV_UPDATE;
                    o_evt.elapsed = e_now;
                    o_evt.thr     = i_cur.thr;
                end
                o_res.done = 1'b1;
            end
            default: begin
                case (i_cur.phase)
                    zdsm_pkg::PH_ABSENT: begin
                        if (i_cur.memb && i_elig) begin
                            o_nxt.phase = zdsm_pkg::PH_PEND_IN;
                        end else begin
                            o_res.done = 1'b1;
                        end
                    end
                    zdsm_pkg::PH_PEND_IN: begin
                        if (!i_cur.memb || !i_elig) begin
                            // the pass after this one cannot move on
                            o_nxt.phase = zdsm_pkg::PH_ABSENT;
                            o_res.done  = 1'b1;
                        end else if (!d_first[31] && d_first >= 32'(i_cfg.enter)) begin
                            o_nxt.phase   = zdsm_pkg::PH_IN;
                            o_nxt.origin  = i_cur.first;
                            o_nxt.report  = i_now;
                            o_nxt.thr     = 1'b0;
                            o_evt.vld     = 1'b1;
                            o_evt.kind    = zdsm_pkg::EV_ENTERED;
                            o_evt.elapsed = d_first;
                        end else begin
                            o_res.done = 1'b1;
                        end
                    end
                    zdsm_pkg::PH_IN: begin
                        if (!i_cur.memb) begin
                            o_nxt.phase = zdsm_pkg::PH_PEND_OUT;
                            o_nxt.left  = i_now;
                        end else begin
                            if (!i_cur.thr && i_cfg.thresh != 27'd0 &&
                                e_now >= 32'(i_cfg.thresh)) begin
                                o_nxt.thr     = 1'b1;
                                o_evt.vld     = 1'b1;
                                o_evt.kind    = zdsm_pkg::EV_THRESHOLD;
                                o_evt.elapsed = e_now;
                                o_evt.thr     = 1'b1;
                            end
                            o_res.upd = 1'b1;
                        end
                    end
                    default: begin
                        if (i_cur.memb) begin
                            o_nxt.phase = zdsm_pkg::PH_IN;
                        end else if (!d_left[31] && d_left >= 32'(i_cfg.leave)) begin
                            o_evt.vld     = 1'b1;
                            o_evt.kind    = zdsm_pkg::EV_EXITED;
                            o_evt.elapsed = d_inside[31] ? 32'd0 : d_inside;
                            o_evt.thr     = i_cur.thr;
                            o_nxt         = '0;
                            o_res.done    = 1'b1;
                        end else begin
                            o_res.done = 1'b1;
                        end
                    end
                endcase
            end
        endcase
    end

endmodule
